// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ngod_pkg.sv -----
// Types, codes and key forming for the n-gram out-of-place distance block.
package ngod_pkg;

  localparam int TEXT_W = 40;
  localparam int LEN_W = 3;
  localparam int KEY_W = TEXT_W + LEN_W;
  localparam int DIST_W = 25;
  localparam int PEN_W = 16;
  localparam int TEXT_CHARS = 5;
  localparam int MAX_GRAM_CHARS = 5;

  localparam logic [PEN_W-1:0] PENALTY_RESET = 16'd400;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_TEST = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TEXT_W-1:0] gram_text;
    logic [LEN_W-1:0]  gram_length;
    logic              last_entry;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              empty_error;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic             last;
  } cmd_t;

  // Clear text bytes at or beyond the clamped length; keep the length as given.
  function automatic logic [KEY_W-1:0] form_key(input logic [TEXT_W-1:0] text,
                                                input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0]  n;
    logic [TEXT_W-1:0] masked;
    n = len;
    if (n > LEN_W'(MAX_GRAM_CHARS)) begin
      n = LEN_W'(MAX_GRAM_CHARS);
    end
    masked = text;
    for (int i = 0; i < TEXT_CHARS; i++) begin
      if (LEN_W'(i) >= n) begin
        masked[8*i +: 8] = 8'd0;
      end
    end
    return {len, masked};
  endfunction

endpackage

// ----- hdl/ngod_fifo.sv -----
// Small first-in first-out queue with full and empty flags.
module ngod_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/ngod_front.sv -----
// Front end: accept items, form the lookup key and queue commands.
module ngod_front (
  input  ngod_pkg::in_item_t item,
  input  logic               push,
  output logic               full,
  output ngod_pkg::cmd_t     cmd,
  output logic               cmd_push,
  input  logic               cmd_full
);
  import ngod_pkg::*;

  assign full         = cmd_full;
  assign cmd.mode     = item.mode;
  assign cmd.key      = form_key(item.gram_text, item.gram_length);
  assign cmd.last     = item.last_entry;
  // Drop the unused mode here so the back end never sees it.
  assign cmd_push     = push && !cmd_full &&
                        (item.mode == MODE_APPEND || item.mode == MODE_TEST ||
                         item.mode == MODE_CLEAR);

endmodule

// ----- hdl/ngod_back.sv -----
// Back end: reference table, sequential search and distance accumulation.
module ngod_back #(
  parameter int PROFILE_DEPTH = 512
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ngod_pkg::cmd_t              cmd,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  input  logic [ngod_pkg::PEN_W-1:0]  miss_penalty,
  output ngod_pkg::out_item_t         res,
  output logic                        res_push,
  input  logic                        res_full
);
  import ngod_pkg::*;

  localparam int AW = (PROFILE_DEPTH > 1) ? $clog2(PROFILE_DEPTH) : 1;
  localparam int CW = $clog2(PROFILE_DEPTH + 1);
  localparam int SW = DIST_W + 1;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  logic [KEY_W-1:0] mem [PROFILE_DEPTH];
  logic [KEY_W-1:0] rd_data;

  logic             state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    rank, rank_next;
  logic [DIST_W-1:0] sum, sum_next;
  logic             dropped, dropped_next;
  logic [AW-1:0]    idx, idx_next;
  logic [KEY_W-1:0] key_q, key_q_next;
  logic             last_q, last_q_next;

  logic             mem_we;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             add_en;
  logic [PEN_W-1:0] add_val;
  logic             finish;
  logic             rank_inc;
  logic             fin_last;
  logic [SW-1:0]    sum_wide;
  logic [DIST_W-1:0] sum_new;
  logic [AW-1:0]    rank_lo;
  logic [AW-1:0]    diff;

  assign rank_lo  = rank[AW-1:0];
  assign diff     = (rank_lo >= idx) ? rank_lo - idx : idx - rank_lo;
  assign sum_wide = {1'b0, sum} + SW'(add_val);
  assign sum_new  = !add_en ? sum : (sum_wide[SW-1] ? DIST_MAX : sum_wide[DIST_W-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= cmd.key;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    rank_next    = rank;
    sum_next     = sum;
    dropped_next = dropped;
    idx_next     = idx;
    key_q_next   = key_q;
    last_q_next  = last_q;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    add_en       = 1'b0;
    add_val      = '0;
    finish       = 1'b0;
    rank_inc     = 1'b0;
    fin_last     = 1'b0;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;

    unique case (state)
      S_IDLE: begin
        cmd_pop = !cmd_empty && !res_full;
        if (cmd_pop) begin
          unique case (cmd.mode)
            MODE_APPEND: begin
              if (count != CW'(PROFILE_DEPTH)) begin
                mem_we     = 1'b1;
                count_next = count + 1'b1;
              end else begin
                dropped_next = 1'b1;
              end
            end
            MODE_CLEAR: begin
              count_next   = '0;
              dropped_next = 1'b0;
            end
            MODE_TEST: begin
              if (rank >= CW'(PROFILE_DEPTH)) begin
                dropped_next = 1'b1;
                finish       = 1'b1;
                fin_last     = cmd.last;
              end else if (count == '0) begin
                finish   = 1'b1;
                rank_inc = 1'b1;
                fin_last = cmd.last;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = '0;
                idx_next    = '0;
                key_q_next  = cmd.key;
                last_q_next = cmd.last;
                state_next  = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (rd_data == key_q) begin
          add_en     = 1'b1;
          add_val    = PEN_W'(diff);
          finish     = 1'b1;
          rank_inc   = 1'b1;
          fin_last   = last_q;
          state_next = S_IDLE;
        end else if (CW'(idx) + 1'b1 == count) begin
          add_en     = 1'b1;
          add_val    = miss_penalty;
          finish     = 1'b1;
          rank_inc   = 1'b1;
          fin_last   = last_q;
          state_next = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx + 1'b1;
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      sum_next  = sum_new;
      rank_next = rank_inc ? rank + 1'b1 : rank;
      if (fin_last) begin
        res_push  = 1'b1;
        rank_next = '0;
        sum_next  = '0;
      end
    end
  end

  always_comb begin
    res.empty_error = (count == '0);
    res.distance    = (count == '0) ? '0 : sum_new;
    res.overflow    = dropped_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      rank    <= '0;
      sum     <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rank    <= rank_next;
      sum     <= sum_next;
      dropped <= dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    key_q  <= key_q_next;
    last_q <= last_q_next;
  end

endmodule

// ----- hdl/ngram_out_of_place_distance.sv -----
// Top level of the n-gram out-of-place distance block.
// Out-of-place distance between a reference n-gram profile and a test profile.
// Items enter through a queue-style port (push/full) with a mode: append a
// reference entry, score a test entry, or clear the reference table. Reference
// entries are stored in rank order in a single-port table of PROFILE_DEPTH keys
// (text masked to its length, plus the length). Each test entry takes the next
// test rank and is searched against the table from rank 0 upward, one table
// read per cycle; the first equal key adds the absolute rank difference, a miss
// adds miss_penalty (reset 400). A test entry with last_entry set delivers one
// result item (distance saturating at 2^25-1, empty_error when the table was
// empty, overflow when any entry fell beyond the table depth) on the
// empty/pop side, then restarts the test rank and the sum. Clear empties the
// table and the overflow flag but keeps the test rank and sum.
// The front end forms the key in the accept cycle and queues it; the
// back end takes one command at a time. Append, clear, a test entry against an
// empty table and a test entry whose rank is beyond the depth finish in the
// idle state with no search. A test entry reads the table from position 0 until
// it matches or has read all count entries, one entry after the other; the one
// read port of the reference table sets this order. Write miss_penalty only
// while no item is in flight.
module ngram_out_of_place_distance #(
  parameter int PROFILE_DEPTH = 512
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  ngod_pkg::in_item_t         item,
  output logic                       empty,
  input  logic                       pop,
  output ngod_pkg::out_item_t        result,
  input  logic                       penalty_we,
  input  logic [ngod_pkg::PEN_W-1:0] penalty_data
);
  import ngod_pkg::*;

  // Depth of the command and result queues.
  localparam int QDEPTH = 2;

  cmd_t             cmd_in;
  cmd_t             cmd_out;
  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_pop;
  logic             cmd_empty;
  out_item_t        res;
  logic             res_push;
  logic             res_full;
  logic [PEN_W-1:0] miss_penalty;

  // Hold the miss penalty register; write it whenever the enable is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      miss_penalty <= PENALTY_RESET;
    end else if (penalty_we) begin
      miss_penalty <= penalty_data;
    end
  end

  // Form the key and drop unused modes at the input.
  ngod_front u_front (
    .item     (item),
    .push     (push),
    .full     (full),
    .cmd      (cmd_in),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full)
  );

  // Decouple the accept side from the searching back end.
  ngod_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QDEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // Search the reference table and accumulate the distance.
  ngod_back #(
    .PROFILE_DEPTH (PROFILE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd_out),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .miss_penalty (miss_penalty),
    .res          (res),
    .res_push     (res_push),
    .res_full     (res_full)
  );

  // Hold finished results until the consumer pops them.
  ngod_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QDEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// ----- hdl/ngod_checker.sv -----
// Port-level checker for the n-gram distance block, bound to the top level.
`include "assert_macros.svh"

module ngod_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input ngod_pkg::out_item_t        result
);

  // An empty table always reports a zero distance.
  `ASSERT_CLK(a_ezero, clk, rst, !empty && result.empty_error |-> ~|result.distance, "bad distance")

  // Reset leaves no result waiting and room for an item.
  `ASSERT_ANY(a_reset_empty, clk, rst |=> empty && !full, "queues not clear after reset")

  // A waiting result holds until it is popped.
  `ASSERT_CLK(a_hold, clk, rst, !empty && !pop |=> !empty && $stable(result), "result moved")

endmodule

bind ngram_out_of_place_distance ngod_checker u_ngod_checker (.*);
